@@ rtl/core/ims_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_pkg: shared types and constants of the interval mass subset sum block
// Item and result word layouts, mode, status and register codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
package ims_pkg;

    localparam int CORE_BITS_DEFAULT  = 10;
    localparam int STATE_BITS_DEFAULT = 32;

    localparam int POS_W       = 48;
    localparam int TOGGLE_W    = 32;
    localparam int QUERY_W     = 10;
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 2;

    localparam logic [POS_W-1:0] MASS_MAX = {POS_W{1'b1}};

    // mode codes
    localparam logic [1:0] MODE_TOGGLE = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_ORDER    = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_STATE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCKING_MASK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_PERIOD  = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [POS_W-1:0]    event_position;
        logic [TOGGLE_W-1:0] toggle_bits;
        logic [QUERY_W-1:0]  query_index;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] entry_value;
        logic [1:0]       status;
    } result_t;

    typedef enum logic [0:0] {
        PHASE_ACCUM,
        PHASE_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ACC_WR,
        ST_QREAD,
        ST_ZLO,
        ST_ZHI,
        ST_ZWR
    } state_t;

endpackage

@@ rtl/core/interval_mass_subset_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_mass_subset_sum: interval mass accumulator with subset-sum transform
// Accumulates interval lengths into a table row picked by the bit state,
// then transforms the table in place and serves row reads.
// ----------------------------------------------------------------------------
// usage:
//   an input word is taken on a clock edge with start high and busy low.
//   every word gives exactly one result word, shown for one cycle with done
//   high; the receiver cannot stall, so it must sample when done is high.
//   toggle event: a read-modify-write of one table row through the shared
//   saturating adder; the write is skipped when the state hits the mask.
//   query: one registered ram read of the asked row.
//   rejected word: result straight from the decode state, status order.
//   finish: closing interval, then the transform, which reads the low row,
//   reads the high row and writes the high row for each row pair on the
//   single ram read port.
//   busy drops in the cycle the result is shown, so the next word may be
//   accepted right then.
//   after reset a clearing pass writes zero to every row with busy high;
//   register writes are taken as ever. Registers are written on any edge
//   with cfg_wr_en high; the user must write them only while the block is
//   idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module interval_mass_subset_sum #(
    parameter int CORE_BITS  = ims_pkg::CORE_BITS_DEFAULT,
    parameter int STATE_BITS = ims_pkg::STATE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ims_pkg::item_t                   item,
    output logic                             done,
    output ims_pkg::result_t                 result,
    input  logic                             cfg_wr_en,
    input  logic [ims_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ims_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ROW_W  = CORE_BITS;
    localparam int ROWS   = 1 << CORE_BITS;
    localparam int PAIR_W = CORE_BITS - 1;
    localparam int BIT_W  = (CORE_BITS > 1) ? $clog2(CORE_BITS) : 1;
    localparam int POS_W  = ims_pkg::POS_W;

    ims_pkg::state_t  state_reg, state_next;
    ims_pkg::phase_t  phase_reg, phase_next;
    logic             started_reg, started_next;
    logic [STATE_BITS-1:0] sweep_state_reg, sweep_state_next;
    logic [STATE_BITS-1:0] init_state_reg, init_state_next;
    logic [STATE_BITS-1:0] block_mask_reg, block_mask_next;
    logic [POS_W-1:0] period_reg, period_next;
    logic [POS_W-1:0] last_pos_reg, last_pos_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] lo_data_reg, lo_data_next;
    logic [1:0]       status_hold_reg, status_hold_next;
    logic [ROW_W-1:0] clr_reg, clr_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    ims_pkg::item_t   item_reg, item_next;
    ims_pkg::result_t result_reg, result_next;
    logic             done_reg, done_next;

    logic             ram_we;
    logic [ROW_W-1:0] ram_waddr;
    logic [POS_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_raddr;
    logic [POS_W-1:0] ram_rdata;
    logic [POS_W-1:0] add_b;
    logic [POS_W-1:0] add_sum;

    logic [POS_W:0]   ev_diff;
    logic [POS_W:0]   fin_diff;
    logic             pos_gt_period;
    logic [31:0]      state_ext;
    logic [ROW_W-1:0] state_row;
    logic             counts;
    logic             q_in_range;
    logic [ROW_W-1:0] q_row;
    logic [ROW_W-1:0] bit_one;
    logic [ROW_W-1:0] low_mask;
    logic [ROW_W-1:0] pair_ext;
    logic [ROW_W-1:0] lo_row;
    logic [ROW_W-1:0] hi_row;

    ims_ram #(
        .WIDTH (POS_W),
        .DEPTH (ROWS)
    ) u_mass_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ims_sat_add u_sat_add (
        .a   (ram_rdata),
        .b   (add_b),
        .sum (add_sum)
    );

    // item checks and row selection
    always_comb
    begin
        ev_diff       = {1'b0, item_reg.event_position} - {1'b0, last_pos_reg};
        fin_diff      = {1'b0, period_reg} - {1'b0, last_pos_reg};
        pos_gt_period = item_reg.event_position > period_reg;
        state_ext     = 32'(sweep_state_reg);
        state_row     = state_ext[ROW_W-1:0];
        counts        = (sweep_state_reg & block_mask_reg) == '0;
        q_in_range    = (32'(item_reg.query_index) >> CORE_BITS) == 32'd0;
        q_row         = ROW_W'(item_reg.query_index);
        // row pair for the transform: insert a zero at the current bit
        bit_one       = ROW_W'(1) << bit_reg;
        low_mask      = bit_one - ROW_W'(1);
        pair_ext      = {1'b0, pair_reg};
        lo_row        = ((pair_ext & ~low_mask) << 1) | (pair_ext & low_mask);
        hi_row        = lo_row | bit_one;
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        started_next     = started_reg;
        sweep_state_next = sweep_state_reg;
        init_state_next  = init_state_reg;
        block_mask_next  = block_mask_reg;
        period_next      = period_reg;
        last_pos_next    = last_pos_reg;
        len_next         = len_reg;
        lo_data_next     = lo_data_reg;
        status_hold_next = status_hold_reg;
        clr_next         = clr_reg;
        pair_next        = pair_reg;
        bit_next         = bit_reg;
        item_next        = item_reg;
        result_next      = result_reg;
        done_next        = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;
        add_b            = len_reg;

        case (state_reg)
            ims_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + ROW_W'(1);
                if (clr_reg == {ROW_W{1'b1}})
                begin
                    state_next = ims_pkg::ST_IDLE;
                end
            end

            ims_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = ims_pkg::ST_DECODE;
                end
            end

            ims_pkg::ST_DECODE:
            begin
                result_next.entry_value = '0;
                result_next.status      = ims_pkg::STATUS_ORDER;
                case (item_reg.mode)
                    ims_pkg::MODE_TOGGLE:
                    begin
                        if (phase_reg == ims_pkg::PHASE_ACCUM && !ev_diff[POS_W]
                            && !pos_gt_period)
                        begin
                            len_next   = ev_diff[POS_W-1:0];
                            ram_raddr  = state_row;
                            state_next = ims_pkg::ST_ACC_WR;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ims_pkg::ST_IDLE;
                        end
                    end
                    ims_pkg::MODE_FINISH:
                    begin
                        if (phase_reg == ims_pkg::PHASE_ACCUM && !fin_diff[POS_W])
                        begin
                            len_next   = fin_diff[POS_W-1:0];
                            ram_raddr  = state_row;
                            state_next = ims_pkg::ST_ACC_WR;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ims_pkg::ST_IDLE;
                        end
                    end
                    ims_pkg::MODE_QUERY:
                    begin
                        if (phase_reg == ims_pkg::PHASE_DONE && q_in_range)
                        begin
                            ram_raddr  = q_row;
                            state_next = ims_pkg::ST_QREAD;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ims_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = ims_pkg::ST_IDLE;
                    end
                endcase
            end

            ims_pkg::ST_ACC_WR:
            begin
                ram_we       = counts;
                ram_waddr    = state_row;
                ram_wdata    = add_sum;
                started_next = 1'b1;
                if (item_reg.mode == ims_pkg::MODE_TOGGLE)
                begin
                    sweep_state_next = sweep_state_reg
                                       ^ item_reg.toggle_bits[STATE_BITS-1:0];
                    last_pos_next           = item_reg.event_position;
                    result_next.entry_value = '0;
                    result_next.status      = ims_pkg::STATUS_OK;
                    done_next               = 1'b1;
                    state_next              = ims_pkg::ST_IDLE;
                end
                else
                begin
                    status_hold_next = (sweep_state_reg == init_state_reg)
                                       ? ims_pkg::STATUS_OK : ims_pkg::STATUS_MISMATCH;
                    bit_next   = '0;
                    pair_next  = '0;
                    state_next = ims_pkg::ST_ZLO;
                end
            end

            ims_pkg::ST_QREAD:
            begin
                result_next.entry_value = ram_rdata;
                result_next.status      = ims_pkg::STATUS_OK;
                done_next               = 1'b1;
                state_next              = ims_pkg::ST_IDLE;
            end

            ims_pkg::ST_ZLO:
            begin
                ram_raddr  = lo_row;
                state_next = ims_pkg::ST_ZHI;
            end

            ims_pkg::ST_ZHI:
            begin
                ram_raddr    = hi_row;
                lo_data_next = ram_rdata;
                state_next   = ims_pkg::ST_ZWR;
            end

            ims_pkg::ST_ZWR:
            begin
                add_b     = lo_data_reg;
                ram_we    = 1'b1;
                ram_waddr = hi_row;
                ram_wdata = add_sum;
                pair_next = pair_reg + PAIR_W'(1);
                if (pair_reg == {PAIR_W{1'b1}})
                begin
                    if (bit_reg == BIT_W'(CORE_BITS - 1))
                    begin
                        phase_next              = ims_pkg::PHASE_DONE;
                        result_next.entry_value = '0;
                        result_next.status      = status_hold_reg;
                        done_next               = 1'b1;
                        state_next              = ims_pkg::ST_IDLE;
                    end
                    else
                    begin
                        bit_next   = bit_reg + BIT_W'(1);
                        state_next = ims_pkg::ST_ZLO;
                    end
                end
                else
                begin
                    state_next = ims_pkg::ST_ZLO;
                end
            end

            default:
            begin
                state_next = ims_pkg::ST_IDLE;
            end
        endcase

        // register writes must arrive only while idle; the block does not enforce it
        if (cfg_wr_en)
        begin
            case (cfg_index)
                ims_pkg::REG_INITIAL_STATE:
                begin
                    init_state_next = cfg_data[STATE_BITS-1:0];
                    if (phase_reg == ims_pkg::PHASE_ACCUM && !started_reg)
                    begin
                        sweep_state_next = cfg_data[STATE_BITS-1:0];
                    end
                end
                ims_pkg::REG_BLOCKING_MASK:
                begin
                    block_mask_next = cfg_data[STATE_BITS-1:0];
                end
                ims_pkg::REG_SWEEP_PERIOD:
                begin
                    period_next = cfg_data[POS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ims_pkg::ST_CLEAR;
            phase_reg       <= ims_pkg::PHASE_ACCUM;
            started_reg     <= 1'b0;
            sweep_state_reg <= '1;
            init_state_reg  <= '1;
            block_mask_reg  <= '0;
            period_reg      <= POS_W'(1);
            last_pos_reg    <= '0;
            clr_reg         <= '0;
            pair_reg        <= '0;
            bit_reg         <= '0;
            status_hold_reg <= ims_pkg::STATUS_OK;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            started_reg     <= started_next;
            sweep_state_reg <= sweep_state_next;
            init_state_reg  <= init_state_next;
            block_mask_reg  <= block_mask_next;
            period_reg      <= period_next;
            last_pos_reg    <= last_pos_next;
            clr_reg         <= clr_next;
            pair_reg        <= pair_next;
            bit_reg         <= bit_next;
            status_hold_reg <= status_hold_next;
            done_reg        <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        len_reg     <= len_next;
        lo_data_reg <= lo_data_next;
        result_reg  <= result_next;
    end

    assign busy   = state_reg != ims_pkg::ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/core/ims_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ims_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ims_sat_add.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_sat_add: shared saturating adder
// Adds two unsigned words and clamps at the all-ones value.
// ----------------------------------------------------------------------------
module ims_sat_add (
    input  logic [ims_pkg::POS_W-1:0] a,
    input  logic [ims_pkg::POS_W-1:0] b,
    output logic [ims_pkg::POS_W-1:0] sum
);

    logic [ims_pkg::POS_W:0] wide;

    always_comb
    begin
        wide = {1'b0, a} + {1'b0, b};
        sum  = wide[ims_pkg::POS_W] ? ims_pkg::MASS_MAX : wide[ims_pkg::POS_W-1:0];
    end

endmodule

@@ test/ims_outcome_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_outcome_check: result checker for the interval mass subset sum block
// Watches the item, result and register ports, keeps its own copy of the
// sweep state and mass table, works out the result word of every accepted
// item and compares it field by field with the word the block returns.
// ----------------------------------------------------------------------------
module ims_outcome_check
    import ims_pkg::*;
#(
    parameter int CORE_BITS  = CORE_BITS_DEFAULT,
    parameter int STATE_BITS = STATE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  item_t                  item,
    input  logic                   done,
    input  result_t                result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     pending_count,
    output int                     fail_count
);

    localparam int ROWS = 1 << CORE_BITS;
    localparam logic [31:0] STATE_MASK = 32'hFFFF_FFFF >> (32 - STATE_BITS);

    logic [POS_W-1:0]    row_mass [ROWS];
    logic [31:0]         sweep_state;
    logic [POS_W-1:0]    last_pos;
    phase_t              phase;
    logic                started;
    logic [31:0]         init_state;
    logic [31:0]         block_mask;
    logic [POS_W-1:0]    period;

    result_t             outcome_fifo [$];

    function automatic logic [POS_W-1:0] sat48(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? MASS_MAX : s[POS_W-1:0];
    endfunction

    function automatic void credit_interval(input logic [POS_W-1:0] len);
        int row;
        if ((sweep_state & block_mask & STATE_MASK) == 32'd0)
        begin
            row = int'(sweep_state[CORE_BITS-1:0]);
            row_mass[row] = sat48(row_mass[row], len);
        end
    endfunction

    // every row ends up holding the sum over all of its subset rows
    function automatic void zeta_fold();
        int b;
        int base;
        int off;
        int stride;
        for (b = 0; b < CORE_BITS; b++)
        begin
            stride = 1 << b;
            for (base = 0; base < ROWS; base += 2 * stride)
                for (off = 0; off < stride; off++)
                    row_mass[base + stride + off] =
                        sat48(row_mass[base + stride + off], row_mass[base + off]);
        end
    endfunction

    function automatic result_t mass_outcome(input item_t it);
        result_t r;
        r.entry_value = '0;
        r.status      = STATUS_ORDER;
        case (it.mode)
            MODE_TOGGLE:
                if (phase == PHASE_ACCUM && it.event_position >= last_pos &&
                    it.event_position <= period)
                begin
                    credit_interval(it.event_position - last_pos);
                    sweep_state = (sweep_state ^ it.toggle_bits) & STATE_MASK;
                    last_pos    = it.event_position;
                    started     = 1'b1;
                    r.status    = STATUS_OK;
                end
            MODE_FINISH:
                if (phase == PHASE_ACCUM && period >= last_pos)
                begin
                    credit_interval(period - last_pos);
                    started  = 1'b1;
                    r.status = (sweep_state == (init_state & STATE_MASK)) ?
                               STATUS_OK : STATUS_MISMATCH;
                    zeta_fold();
                    phase = PHASE_DONE;
                end
            MODE_QUERY:
                if (phase == PHASE_DONE && int'(it.query_index) < ROWS)
                begin
                    r.entry_value = row_mass[it.query_index];
                    r.status      = STATUS_OK;
                end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void write_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_INITIAL_STATE:
            begin
                init_state = val[31:0];
                // before the sweep has begun the running state follows it
                if (phase == PHASE_ACCUM && !started)
                    sweep_state = init_state & STATE_MASK;
            end
            REG_BLOCKING_MASK: block_mask = val[31:0];
            REG_SWEEP_PERIOD:  period = val[POS_W-1:0];
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t fresh;
        int      errs;
        int      i;
        if (!rst_n)
        begin
            for (i = 0; i < ROWS; i++)
                row_mass[i] = '0;
            init_state  = 32'hFFFF_FFFF;
            block_mask  = 32'd0;
            period      = 48'd1;
            sweep_state = init_state & STATE_MASK;
            last_pos    = '0;
            phase       = PHASE_ACCUM;
            started     = 1'b0;
            outcome_fifo.delete();
            pending_count <= 0;
            fail_count    <= 0;
        end
        else
        begin
            errs = 0;
            if (done)
            begin
                if (outcome_fifo.size() == 0)
                begin
                    $error("result word with no item waiting for it");
                    errs++;
                end
                else
                begin
                    want = outcome_fifo.pop_front();
                    if (result.entry_value !== want.entry_value)
                    begin
                        $error("entry_value: expected %0h, got %0h",
                               want.entry_value, result.entry_value);
                        errs++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        errs++;
                    end
                end
            end
            if (start && !busy)
            begin
                fresh        = mass_outcome(item);
                outcome_fifo = {outcome_fifo, fresh};
            end
            if (cfg_wr_en)
                write_register(cfg_index, cfg_data);
            pending_count <= outcome_fifo.size();
            fail_count    <= fail_count + errs;
        end
    end

endmodule

@@ test/tb_interval_mass_subset_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_mass_subset_sum: testbench of the interval mass subset sum block
// Runs one sweep: directed corner items, then blocks of random sorted toggle
// events under changing register settings mixed with out-of-order noise, the
// finish with its transform, and random row queries. A checker beside the
// block predicts every result word; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_interval_mass_subset_sum;
    import ims_pkg::*;

    localparam int          QUIET_LIMIT = 80000;
    localparam int          BLOCK_ITEMS = 275;
    localparam int          QUERY_ITEMS = 560;
    // mode 3 has no meaning and must be turned away
    localparam logic [1:0]  MODE_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    item_t                  item;
    logic                   done;
    result_t                result;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     pending_count;
    int                     fail_count;
    int                     quiet_cycles;

    // stimulus-side view of the sweep, used to build well-formed events
    logic [POS_W-1:0]       pos_cursor;
    logic [POS_W-1:0]       period_now;
    logic [31:0]            state_track;
    logic                   transformed;
    logic                   idle_on;

    interval_mass_subset_sum u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ims_outcome_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .done          (done),
        .result        (result),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending_count (pending_count),
        .fail_count    (fail_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_interval_mass_subset_sum failed");
            $finish;
        end
    end

    function automatic logic [POS_W-1:0] rand48();
        return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
    endfunction

    function automatic logic [31:0] rand_toggle();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd1 << $urandom_range(0, 31);
            2:       return 32'hFFFF_FFFF;
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic item_t noise_item();
        item_t w;
        w.mode           = 2'($urandom_range(0, 3));
        w.event_position = rand48();
        w.toggle_bits    = 32'($urandom);
        w.query_index    = 10'($urandom_range(0, 1023));
        return w;
    endfunction

    // forward step from the cursor, clipped at the current period
    function automatic logic [POS_W-1:0] next_position();
        logic [POS_W-1:0] stride;
        case ($urandom_range(0, 9))
            0:       stride = '0;
            1:       stride = 48'($urandom);
            default: stride = 48'($urandom_range(1, 4096));
        endcase
        if (stride > period_now - pos_cursor)
            stride = period_now - pos_cursor;
        return pos_cursor + stride;
    endfunction

    task automatic send(input item_t w);
        item  <= w;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 7));
    endtask

    // wait until every result word has come back
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        if (idx == REG_SWEEP_PERIOD)
            period_now = val;
    endtask

    task automatic send_mode(input logic [1:0] m);
        item_t w;
        w      = noise_item();
        w.mode = m;
        send(w);
    endtask

    task automatic send_event(input logic [POS_W-1:0] pos, input logic [31:0] tog);
        item_t w;
        w                = noise_item();
        w.mode           = MODE_TOGGLE;
        w.event_position = pos;
        w.toggle_bits    = tog;
        if (!transformed && pos >= pos_cursor && pos <= period_now)
        begin
            pos_cursor  = pos;
            state_track = state_track ^ tog;
        end
        send(w);
    endtask

    task automatic send_query(input logic [QUERY_W-1:0] idx);
        item_t w;
        w             = noise_item();
        w.mode        = MODE_QUERY;
        w.query_index = idx;
        send(w);
    endtask

    initial
    begin
        logic [31:0] mask_pick;
        logic [31:0] init_pick;
        int          kind;
        int          blk;
        int          n;

        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_INITIAL_STATE;
        cfg_data    = '0;
        quiet_cycles = 0;
        pos_cursor  = '0;
        period_now  = 48'd1;
        state_track = 32'd0;
        transformed = 1'b0;
        idle_on     = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // initial state written before any item also loads the running state
        write_reg(REG_INITIAL_STATE, 48'hFFFF_FFFF);
        write_reg(REG_INITIAL_STATE, 48'h0);
        write_reg(REG_BLOCKING_MASK, 48'h0);
        cfg_wr_en <= 1'b0;
        state_track = 32'd0;

        // period still at its reset value of one
        send_event(48'd0, 32'd0);
        send_event(48'd1, 32'hFFFF_FFFF);
        send_event(48'd2, rand_toggle());       // beyond the period
        send_event(48'd0, rand_toggle());       // going backwards
        send_mode(MODE_QUERY);                  // query before the transform
        send_mode(MODE_UNUSED);
        send_event(48'd1, 32'hFFFF_FFFF);       // zero-length interval

        settle();
        write_reg(REG_SWEEP_PERIOD, MASS_MAX);
        write_reg(REG_BLOCKING_MASK, 48'h8000_0000);
        // sweep already started, so the running state must not reload
        write_reg(REG_INITIAL_STATE, 48'hFFFF_FFFF);
        cfg_wr_en <= 1'b0;
        send_event(48'd1000, 32'h8000_0001);
        send_event(48'd5000, 32'd0);            // blocked interval
        send_event(48'd5000, 32'h8000_0000);
        send_event(48'h100_0000_0000, 32'h0000_03FE);
        send_event(48'h0FF_FFFF_FFFF, rand_toggle());

        // finish with the period below the last position is turned away
        settle();
        write_reg(REG_SWEEP_PERIOD, 48'h0FF_FFFF_FFFF);
        cfg_wr_en <= 1'b0;
        send_mode(MODE_FINISH);
        send_event(48'h100_0000_0000, rand_toggle());

        for (blk = 0; blk < 4; blk++)
        begin
            settle();
            case (blk)
                0:       mask_pick = 32'hFFFF_FFFF;
                1:       mask_pick = 32'd1 << $urandom_range(CORE_BITS_DEFAULT, 31);
                2:       mask_pick = $urandom & $urandom & $urandom;
                default: mask_pick = 32'd0;
            endcase
            write_reg(REG_BLOCKING_MASK, {16'd0, mask_pick});
            write_reg(REG_INITIAL_STATE, {16'd0, 32'($urandom)});
            case (blk)
                0:       write_reg(REG_SWEEP_PERIOD,
                                   pos_cursor + 48'($urandom_range(50000, 400000)));
                2:       write_reg(REG_SWEEP_PERIOD, pos_cursor + 48'($urandom));
                default: write_reg(REG_SWEEP_PERIOD, MASS_MAX);
            endcase
            cfg_wr_en <= 1'b0;
            for (n = 0; n < BLOCK_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    idle_on = ($urandom_range(0, 2) != 0);
                kind = $urandom_range(0, 99);
                if (kind < 80)
                    send_event(next_position(), rand_toggle());
                else if (kind < 85 && pos_cursor != '0)
                    send_event(rand48() % pos_cursor, rand_toggle());
                else if (kind < 90 && period_now != MASS_MAX)
                    send_event(period_now + 48'd1 + rand48() % (MASS_MAX - period_now),
                               rand_toggle());
                else if (kind < 96)
                    send_mode(MODE_UNUSED);
                else
                    send_mode(MODE_QUERY);
                maybe_idle();
            end
        end

        // closing interval runs to the far end; state check passes or fails at random
        settle();
        write_reg(REG_SWEEP_PERIOD, MASS_MAX);
        write_reg(REG_BLOCKING_MASK, 48'h0);
        if ($urandom_range(0, 1) == 0)
            init_pick = state_track;
        else
            init_pick = state_track ^ (32'd1 << $urandom_range(0, 31));
        write_reg(REG_INITIAL_STATE, {16'd0, init_pick});
        cfg_wr_en <= 1'b0;
        send_mode(MODE_FINISH);
        transformed = 1'b1;

        send_query('0);
        send_query(10'd1);
        send_query('1);
        idle_on = 1'b1;
        for (n = 0; n < QUERY_ITEMS; n++)
        begin
            if (n >= QUERY_ITEMS - 150)
                idle_on = 1'b0;
            else if (n % 40 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 85)
                send_query(10'($urandom_range(0, 1023)));
            else if (kind < 90)
                send_event(rand48(), rand_toggle());    // wrong phase
            else if (kind < 94)
                send_mode(MODE_FINISH);                 // wrong phase
            else
                send_mode(MODE_UNUSED);
            maybe_idle();
        end

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_interval_mass_subset_sum passed");
        else
            $display("tb_interval_mass_subset_sum failed");
        $finish;
    end

endmodule
